/* rtl/hptc_pkg.sv */
// ----------------------------------------------------------------------------
// hptc_pkg
// Widths, register map, reset values and types shared by the heading PID
// turn controller files.
// ----------------------------------------------------------------------------
package hptc_pkg;

    // payload field widths
    localparam int POS_W   = 21;
    localparam int VEL_W   = 11;
    localparam int DRV_W   = 16;
    localparam int ERR_W   = 22;
    localparam int TGT_W   = 11;
    localparam int GAIN_W  = 16;
    localparam int PTOL_W  = 12;
    localparam int VTOL_W  = 10;
    localparam int INTEG_W = 32;

    // apb port
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_TARGET_ANGLE = 3'd0;
    localparam logic [2:0] REG_LOOP_ENABLE  = 3'd1;
    localparam logic [2:0] REG_GAIN_P       = 3'd2;
    localparam logic [2:0] REG_GAIN_I       = 3'd3;
    localparam logic [2:0] REG_GAIN_D       = 3'd4;
    localparam logic [2:0] REG_POS_TOL      = 3'd5;
    localparam logic [2:0] REG_VEL_TOL      = 3'd6;

    // register reset values
    localparam logic [GAIN_W-1:0] RST_GAIN_P  = 16'd256;
    localparam logic [GAIN_W-1:0] RST_GAIN_I  = 16'd128;
    localparam logic [GAIN_W-1:0] RST_GAIN_D  = 16'd1280;
    localparam logic [PTOL_W-1:0] RST_POS_TOL = 12'd5;
    localparam logic [VTOL_W-1:0] RST_VEL_TOL = 10'd10;

    // datapath widths: signed gain is 17 bits
    localparam int PE_W   = GAIN_W + 1 + ERR_W;       // kp*err, kd*deriv
    localparam int PI_W   = GAIN_W + 1 + INTEG_W;     // ki*integral
    localparam int SUM_W  = PI_W + 1;
    localparam int SCL_W  = SUM_W + 4;                // times ten
    localparam int QUO_W  = SCL_W - 8;                // after / 256

    localparam logic signed [DRV_W-1:0] DRV_MAX = 16'sh7fff;
    localparam logic signed [DRV_W-1:0] DRV_MIN = 16'sh8000;

    typedef struct packed {
        logic signed [TGT_W-1:0] target_angle;
        logic                    loop_enable;
        logic [GAIN_W-1:0]       gain_p;
        logic [GAIN_W-1:0]       gain_i;
        logic [GAIN_W-1:0]       gain_d;
        logic [PTOL_W-1:0]       pos_tol;
        logic [VTOL_W-1:0]       vel_tol;
    } t_cfg;

endpackage

/* rtl/hptc_tick_if.sv */
// ----------------------------------------------------------------------------
// hptc_tick_if
// Control tick channel: measured position and velocity with valid/ready.
// ----------------------------------------------------------------------------
interface hptc_tick_if;
    logic                                valid;
    logic                                ready;
    logic signed [hptc_pkg::POS_W-1:0]   measured_position;
    logic signed [hptc_pkg::VEL_W-1:0]   measured_velocity;

    modport source (output valid, measured_position, measured_velocity, input ready);
    modport sink   (input valid, measured_position, measured_velocity, output ready);
endinterface

/* rtl/hptc_result_if.sv */
// ----------------------------------------------------------------------------
// hptc_result_if
// Result channel: drive commands, heading error and settled flag.
// ----------------------------------------------------------------------------
interface hptc_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [hptc_pkg::DRV_W-1:0]   drive_left;
    logic signed [hptc_pkg::DRV_W-1:0]   drive_right;
    logic signed [hptc_pkg::ERR_W-1:0]   heading_error;
    logic                                is_settled;

    modport source (output valid, drive_left, drive_right, heading_error, is_settled,
                    input ready);
    modport sink   (input valid, drive_left, drive_right, heading_error, is_settled,
                    output ready);
endinterface

/* rtl/heading_pid_turn_controller_unit.sv */
// ----------------------------------------------------------------------------
// heading_pid_turn_controller_unit
// Heading PID with derivative on measurement; drive is ten times the Q8.8
// controller sum, truncated toward zero and saturated, right = -left.
// ----------------------------------------------------------------------------
// an accepted request goes to the input register, then on to the result register
// one request per cycle while results are taken; input and result registers hold one each
// controller state is updated at the accept edge, so back-to-back ticks see it
// disabled ticks are accepted and dropped without touching state
// reset (synchronous, active low) restores register defaults, clears the
// integral, previous error and position, and marks the next tick as first
module heading_pid_turn_controller_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    hptc_tick_if.sink                    i_tick,
    hptc_result_if.source                o_result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hptc_pkg::APB_AW-1:0]  paddr,
    input  logic [hptc_pkg::APB_DW-1:0]  pwdata,
    output logic [hptc_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import hptc_pkg::*;

    // ---------------- configuration ----------------
    t_cfg       r_cfg;
    logic       cfg_wr;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[APB_AW-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_angle <= '0;
            r_cfg.loop_enable  <= 1'b1;
            r_cfg.gain_p       <= RST_GAIN_P;
            r_cfg.gain_i       <= RST_GAIN_I;
            r_cfg.gain_d       <= RST_GAIN_D;
            r_cfg.pos_tol      <= RST_POS_TOL;
            r_cfg.vel_tol      <= RST_VEL_TOL;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_TARGET_ANGLE: r_cfg.target_angle <= signed'(pwdata[TGT_W-1:0]);
                REG_LOOP_ENABLE:  r_cfg.loop_enable  <= pwdata[0];
                REG_GAIN_P:       r_cfg.gain_p       <= pwdata[GAIN_W-1:0];
                REG_GAIN_I:       r_cfg.gain_i       <= pwdata[GAIN_W-1:0];
                REG_GAIN_D:       r_cfg.gain_d       <= pwdata[GAIN_W-1:0];
                REG_POS_TOL:      r_cfg.pos_tol      <= pwdata[PTOL_W-1:0];
                REG_VEL_TOL:      r_cfg.vel_tol      <= pwdata[VTOL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_TARGET_ANGLE: prdata = {{(APB_DW-TGT_W){1'b0}}, r_cfg.target_angle};
            REG_LOOP_ENABLE:  prdata = {{(APB_DW-1){1'b0}}, r_cfg.loop_enable};
            REG_GAIN_P:       prdata = {{(APB_DW-GAIN_W){1'b0}}, r_cfg.gain_p};
            REG_GAIN_I:       prdata = {{(APB_DW-GAIN_W){1'b0}}, r_cfg.gain_i};
            REG_GAIN_D:       prdata = {{(APB_DW-GAIN_W){1'b0}}, r_cfg.gain_d};
            REG_POS_TOL:      prdata = {{(APB_DW-PTOL_W){1'b0}}, r_cfg.pos_tol};
            REG_VEL_TOL:      prdata = {{(APB_DW-VTOL_W){1'b0}}, r_cfg.vel_tol};
            default:          prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    logic r_s1_v, r_out_v;
    logic take_s1, take_out;
    logic tick_acc, tick_run;

    assign take_out = !r_out_v || o_result.ready;
    assign take_s1  = !r_s1_v || take_out;

    assign i_tick.ready = take_s1;
    assign tick_acc     = i_tick.valid && take_s1;
    assign tick_run     = tick_acc && r_cfg.loop_enable;

    // ---------------- controller state and front end ----------------
    logic signed [INTEG_W-1:0] r_integ;
    logic signed [ERR_W-1:0]   r_prev_err;
    logic signed [POS_W-1:0]   r_prev_pos;
    logic                      r_first;

    logic signed [TGT_W:0]     tgt_ext;
    logic signed [TGT_W:0]     tgt_wrap;
    logic signed [ERR_W-1:0]   n_err;
    logic signed [ERR_W-1:0]   n_deriv;
    logic signed [INTEG_W:0]   integ_sum;
    logic signed [INTEG_W-1:0] n_integ;

    always_comb begin
        tgt_ext = {r_cfg.target_angle[TGT_W-1], r_cfg.target_angle};
        // single wrap: above 180 loses 360, below -180 gains 360
        if (tgt_ext > 12'sd180) begin
            tgt_wrap = tgt_ext - 12'sd360;
        end else if (tgt_ext < -12'sd180) begin
            tgt_wrap = tgt_ext + 12'sd360;
        end else begin
            tgt_wrap = tgt_ext;
        end

        n_err = ERR_W'(tgt_wrap) - ERR_W'(i_tick.measured_position);

        if (r_first) begin
            n_deriv = '0;
        end else begin
            n_deriv = ERR_W'(i_tick.measured_position) - ERR_W'(r_prev_pos);
        end

        // integral takes the previous tick's error, saturated to 32 bits
        integ_sum = (INTEG_W+1)'(r_integ) + (INTEG_W+1)'(r_prev_err);
        if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
            n_integ = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                         : {1'b0, {(INTEG_W-1){1'b1}}};
        end else begin
            n_integ = integ_sum[INTEG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ    <= '0;
            r_prev_err <= '0;
            r_prev_pos <= '0;
            r_first    <= 1'b1;
        end else if (tick_run) begin
            r_integ    <= n_integ;
            r_prev_err <= n_err;
            r_prev_pos <= i_tick.measured_position;
            r_first    <= 1'b0;
        end
    end

    // ---------------- stage valids ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (take_s1)  r_s1_v  <= tick_run;
            if (take_out) r_out_v <= r_s1_v;
        end
    end

    // ------------- input register: error, derivative, integral, velocity -------------
    logic signed [ERR_W-1:0]   r_s1_err;
    logic signed [ERR_W-1:0]   r_s1_deriv;
    logic signed [INTEG_W-1:0] r_s1_integ;
    logic signed [VEL_W-1:0]   r_s1_vel;

    always_ff @(posedge i_clk) begin
        if (take_s1) begin
            r_s1_err   <= n_err;
            r_s1_deriv <= n_deriv;
            r_s1_integ <= n_integ;
            r_s1_vel   <= i_tick.measured_velocity;
        end
    end

    // ---------------- gain products, settled flag, controller sum ----------------
    logic signed [PE_W-1:0]  n_prod_p, n_prod_d;
    logic signed [PI_W-1:0]  n_prod_i;
    logic [ERR_W-1:0]        abs_err;
    logic [VEL_W-1:0]        abs_vel;
    logic                    n_settled;
    logic signed [SUM_W-1:0] n_sum;

    always_comb begin
        n_prod_p = signed'({1'b0, r_cfg.gain_p}) * r_s1_err;
        n_prod_d = signed'({1'b0, r_cfg.gain_d}) * r_s1_deriv;
        n_prod_i = signed'({1'b0, r_cfg.gain_i}) * r_s1_integ;

        abs_err   = r_s1_err[ERR_W-1] ? ERR_W'(-r_s1_err) : ERR_W'(r_s1_err);
        abs_vel   = r_s1_vel[VEL_W-1] ? VEL_W'(-r_s1_vel) : VEL_W'(r_s1_vel);
        n_settled = (abs_err < ERR_W'(r_cfg.pos_tol)) && (abs_vel < VEL_W'(r_cfg.vel_tol));
    end

    assign n_sum = SUM_W'(n_prod_p) - SUM_W'(n_prod_d) + SUM_W'(n_prod_i);

    // ---------------- output: scale by ten, / 256 toward zero, saturate ----------------
    logic signed [SCL_W-1:0] scaled;
    logic signed [SCL_W-1:0] biased;
    logic signed [QUO_W-1:0] quo;
    logic signed [DRV_W-1:0] n_left, n_right;

    always_comb begin
        scaled = (SCL_W'(n_sum) <<< 3) + (SCL_W'(n_sum) <<< 1);
        // negative values get 255 added so the shift truncates toward zero
        biased = scaled[SCL_W-1] ? scaled + SCL_W'(255) : scaled;
        quo    = QUO_W'(biased >>> 8);

        if (quo > QUO_W'(DRV_MAX)) begin
            n_left = DRV_MAX;
        end else if (quo < QUO_W'(DRV_MIN)) begin
            n_left = DRV_MIN;
        end else begin
            n_left = quo[DRV_W-1:0];
        end

        n_right = (n_left == DRV_MIN) ? DRV_MAX : DRV_W'(-n_left);
    end

    logic signed [DRV_W-1:0] r_out_left, r_out_right;
    logic signed [ERR_W-1:0] r_out_err;
    logic                    r_out_settled;

    always_ff @(posedge i_clk) begin
        if (take_out) begin
            r_out_left    <= n_left;
            r_out_right   <= n_right;
            r_out_err     <= r_s1_err;
            r_out_settled <= n_settled;
        end
    end

    assign o_result.valid         = r_out_v;
    assign o_result.drive_left    = r_out_left;
    assign o_result.drive_right   = r_out_right;
    assign o_result.heading_error = r_out_err;
    assign o_result.is_settled    = r_out_settled;

    // ---------------- assertions ----------------
    // first enabled tick after reset carries a zero derivative
    a_first_deriv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tick_run && r_first) |=> (r_s1_deriv == '0))
        else $error("first tick derivative not zero");

    // controller state only moves on an enabled accepted tick
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !tick_run |=> ($stable(r_integ) && $stable(r_prev_err) && $stable(r_prev_pos)))
        else $error("controller state changed without a tick");

    // a disabled tick never enters the pipeline
    a_disabled_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tick_acc && !r_cfg.loop_enable) |=> !r_s1_v)
        else $error("disabled tick produced a pipeline item");

    // right drive is the saturated negation of left
    a_right_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> ((r_out_left == DRV_MIN && r_out_right == DRV_MAX) ||
                     (r_out_left != DRV_MIN && r_out_right == DRV_W'(-r_out_left))))
        else $error("right drive mismatch");

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the heading PID turn controller. A directed table
// and then random ticks go through the tick channel under several idle and
// stall mixes. Each enabled tick is predicted by a local model of the controller
// or by the directed table, and results are checked in order. Registers are written
// over APB only while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_top;
    import hptc_pkg::*;

    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 4;
    localparam int DRAIN_CYCLES    = 8;
    localparam int HOLD_CYCLES     = 400;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int RANDOM_PHASES   = 8;
    localparam int TICKS_PER_PHASE = 100;
    localparam int MAX_REPORTS     = 10;
    localparam logic [2:0] REG_UNMAPPED = 3'd7;
    localparam longint INTEG_MAX = 64'sh7fff_ffff;
    localparam longint INTEG_MIN = -64'sh8000_0000;

    typedef enum {ROW_CFG, ROW_TICK} t_row_kind;
    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    typedef struct {
        logic signed [DRV_W-1:0] drive_left;
        logic signed [DRV_W-1:0] drive_right;
        logic signed [ERR_W-1:0] heading_error;
        logic                    is_settled;
    } t_drive_cmd;

    typedef struct {
        t_row_kind         kind;
        logic [2:0]        reg_idx;
        logic [APB_DW-1:0] wdata;
        int                position;
        int                velocity;
        bit                known;
        t_drive_cmd        cmd;
    } t_stim_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    hptc_tick_if   tick_ch ();
    hptc_result_if result_ch ();

    heading_pid_turn_controller_unit uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (tick_ch),
        .o_result (result_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // controller model state and register copy
    t_cfg   shadow_cfg;
    longint integ_acc;
    longint last_err;
    longint last_pos;
    bit     first_tick_due;

    t_drive_cmd drive_expect_q[$];
    t_stim_row  directed_rows[$];

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   mismatch_cnt   = 0;
    int   cycle_cnt      = 0;
    logic hold_active    = 1'b0;
    event hold_go;

    function automatic longint clamp_range(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint wrapped_target();
        longint t;
        t = longint'($signed(shadow_cfg.target_angle));
        if (t > 180) t -= 360;
        else if (t < -180) t += 360;
        return t;
    endfunction

    // one enabled tick: updates the controller state, returns the drive request
    function automatic t_drive_cmd compute_drive(int pos, int vel);
        longint     err;
        longint     deriv;
        longint     sum;
        longint     left;
        longint     right;
        t_drive_cmd c;
        err       = wrapped_target() - longint'(pos);
        integ_acc = clamp_range(integ_acc + last_err, INTEG_MIN, INTEG_MAX);
        deriv     = first_tick_due ? 0 : longint'(pos) - last_pos;
        sum = longint'(shadow_cfg.gain_p) * err
            - longint'(shadow_cfg.gain_d) * deriv
            + longint'(shadow_cfg.gain_i) * integ_acc;
        left  = clamp_range((sum * 10) / 256, -32768, 32767);
        right = clamp_range(-left, -32768, 32767);
        c.drive_left    = DRV_W'(left);
        c.drive_right   = DRV_W'(right);
        c.heading_error = ERR_W'(err);
        c.is_settled    = ((err < 0 ? -err : err) < longint'(shadow_cfg.pos_tol)) &&
                          ((vel < 0 ? -vel : vel) < int'(shadow_cfg.vel_tol));
        last_err       = err;
        last_pos       = pos;
        first_tick_due = 1'b0;
        return c;
    endfunction

    function automatic void note_failure(string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS) $display("%s", msg);
    endfunction

    function automatic void set_idle(t_idle_mode m);
        case (m)
            IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 83; recv_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 83; end
            default:   begin send_idle_pct = 23; recv_stall_pct = 23; end
        endcase
    endfunction

    function automatic void add_cfg(logic [2:0] idx, logic [APB_DW-1:0] data);
        t_stim_row r;
        r.kind    = ROW_CFG;
        r.reg_idx = idx;
        r.wdata   = data;
        r.known   = 1'b0;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_tick(int pos, int vel, bit known = 1'b0, int left = 0,
                                     int right = 0, int err = 0, bit settled = 1'b0);
        t_stim_row r;
        r.kind                = ROW_TICK;
        r.position            = pos;
        r.velocity            = vel;
        r.known               = known;
        r.cmd.drive_left      = DRV_W'(left);
        r.cmd.drive_right     = DRV_W'(right);
        r.cmd.heading_error   = ERR_W'(err);
        r.cmd.is_settled      = settled;
        directed_rows.push_back(r);
    endfunction

    function automatic int random_position();
        int t;
        t = int'(wrapped_target());
        case ($urandom_range(9, 0))
            0, 1, 2, 3, 4, 5: return t + int'($urandom_range(40, 0)) - 20;
            6, 7:             return int'($urandom_range(1200, 0)) - 600;
            8:                return int'($urandom) >>> 11;
            default:          return ($urandom_range(1, 0) == 1) ? 1048575 : -1048576;
        endcase
    endfunction

    function automatic int random_velocity();
        int tol;
        int v;
        tol = int'(shadow_cfg.vel_tol);
        if ($urandom_range(1, 0) == 0) begin
            // cluster around the settle tolerance
            v = int'($urandom_range(2 * tol + 4, 0)) - tol - 2;
            if (v > 1023) v = 1023;
            if (v < -1024) v = -1024;
        end else begin
            v = int'($urandom) >>> 21;
        end
        return v;
    endfunction

    function automatic int random_gain();
        case ($urandom_range(5, 0))
            0:       return 0;
            1:       return $urandom_range(15, 0);
            2, 3:    return $urandom_range(1023, 0);
            4:       return 65535;
            default: return int'($urandom);
        endcase
    endfunction

    // wait until every expected result is back, then let the pipeline empty
    task automatic drain_results();
        tick_ch.valid <= 1'b0;
        while (drive_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [APB_DW-1:0] data);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_TARGET_ANGLE: shadow_cfg.target_angle = data[TGT_W-1:0];
            REG_LOOP_ENABLE:  shadow_cfg.loop_enable  = data[0];
            REG_GAIN_P:       shadow_cfg.gain_p       = data[GAIN_W-1:0];
            REG_GAIN_I:       shadow_cfg.gain_i       = data[GAIN_W-1:0];
            REG_GAIN_D:       shadow_cfg.gain_d       = data[GAIN_W-1:0];
            REG_POS_TOL:      shadow_cfg.pos_tol      = data[PTOL_W-1:0];
            REG_VEL_TOL:      shadow_cfg.vel_tol      = data[VTOL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_tick(int pos, int vel, bit known, t_drive_cmd known_cmd);
        t_drive_cmd c;
        while ($urandom_range(99, 0) < send_idle_pct) begin
            tick_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        tick_ch.valid             <= 1'b1;
        tick_ch.measured_position <= POS_W'(pos);
        tick_ch.measured_velocity <= VEL_W'(vel);
        do @(posedge i_clk); while (tick_ch.ready !== 1'b1);
        if (shadow_cfg.loop_enable) begin
            c = compute_drive(pos, vel);
            drive_expect_q.push_back(known ? known_cmd : c);
        end
    endtask

    task automatic randomize_config();
        int v;
        case ($urandom_range(3, 0))
            0:       v = int'($urandom_range(1080, 0)) - 540;
            1:       v = int'($urandom_range(360, 0)) - 180;
            2:       v = ($urandom_range(1, 0) == 1) ? 540 : -540;
            default: v = int'($urandom);
        endcase
        write_reg(REG_TARGET_ANGLE, v);
        write_reg(REG_GAIN_P, random_gain());
        write_reg(REG_GAIN_D, random_gain());
        // the integral winds up fast, so keep its gain mostly off
        write_reg(REG_GAIN_I, ($urandom_range(1, 0) == 1) ? 0 : random_gain());
        write_reg(REG_POS_TOL, ($urandom_range(7, 0) == 0) ? 4095 : $urandom_range(30, 0));
        write_reg(REG_VEL_TOL, ($urandom_range(7, 0) == 0) ? 1023 : $urandom_range(30, 0));
        write_reg(REG_LOOP_ENABLE, 1);
    endtask

    function automatic void build_directed_table();
        // defaults after reset: first tick, then both position extremes
        add_tick(0, 0, 1'b1, 0, 0, 0, 1'b1);
        add_tick(-1048576, 0, 1'b1, 32767, -32767, 1048576, 1'b0);
        add_tick(1048575, 0, 1'b1, -32768, 32767, -1048575, 1'b0);
        // settle flag edges and velocity extremes
        add_tick(4, 9);
        add_tick(-5, -9);
        add_tick(2, 10);
        add_tick(0, -1024);
        add_tick(0, 1023);
        // truncation toward zero on small negative sums
        add_cfg(REG_GAIN_P, 1);
        add_cfg(REG_GAIN_I, 0);
        add_cfg(REG_GAIN_D, 0);
        add_tick(1, 0);
        add_tick(26, 0);
        add_tick(-26, 0);
        // target wrap, once only, plus masking to 11 bits
        add_cfg(REG_TARGET_ANGLE, 181);
        add_tick(0, 0);
        add_cfg(REG_TARGET_ANGLE, -181);
        add_tick(0, 0);
        add_cfg(REG_TARGET_ANGLE, 540);
        add_tick(0, 0);
        add_cfg(REG_TARGET_ANGLE, -540);
        add_tick(0, 0);
        add_cfg(REG_TARGET_ANGLE, 32'hffff_ffff);
        add_tick(0, 0);
        add_cfg(REG_TARGET_ANGLE, 1023);
        add_tick(0, 0);
        add_cfg(REG_TARGET_ANGLE, 32'h0000_0400);
        add_tick(0, 0);
        // disabled loop drops ticks; only bit 0 of the enable counts
        add_cfg(REG_LOOP_ENABLE, 0);
        add_tick(100, 5);
        add_cfg(REG_LOOP_ENABLE, 2);
        add_tick(200, 0);
        add_cfg(REG_LOOP_ENABLE, 1);
        add_tick(50, 3);
        // everything at its top value, written with all ones
        add_cfg(REG_GAIN_P, 32'hffff_ffff);
        add_cfg(REG_GAIN_I, 32'hffff_ffff);
        add_cfg(REG_GAIN_D, 32'hffff_ffff);
        add_cfg(REG_POS_TOL, 32'hffff_ffff);
        add_cfg(REG_VEL_TOL, 32'hffff_ffff);
        add_tick(-4758, -1022);
        add_tick(3431, 1023);
        add_cfg(REG_POS_TOL, 0);
        add_cfg(REG_VEL_TOL, 0);
        add_tick(-664, 0);
        add_cfg(REG_UNMAPPED, 32'hffff_ffff);
        add_tick(-600, 1);
    endfunction

    always @(posedge i_clk) begin : result_monitor
        t_drive_cmd exp_cmd;
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else begin
            if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
                if (drive_expect_q.size() == 0) begin
                    note_failure($sformatf("result without request: left %0d error %0d",
                                           result_ch.drive_left, result_ch.heading_error));
                end else begin
                    exp_cmd = drive_expect_q.pop_front();
                    if (result_ch.drive_left !== exp_cmd.drive_left)
                        note_failure($sformatf("drive_left: expected %0d, got %0d",
                                               exp_cmd.drive_left, result_ch.drive_left));
                    if (result_ch.drive_right !== exp_cmd.drive_right)
                        note_failure($sformatf("drive_right: expected %0d, got %0d",
                                               exp_cmd.drive_right, result_ch.drive_right));
                    if (result_ch.heading_error !== exp_cmd.heading_error)
                        note_failure($sformatf("heading_error: expected %0d, got %0d",
                                               exp_cmd.heading_error,
                                               result_ch.heading_error));
                    if (result_ch.is_settled !== exp_cmd.is_settled)
                        note_failure($sformatf("is_settled: expected %0b, got %0b",
                                               exp_cmd.is_settled, result_ch.is_settled));
                end
            end
            result_ch.ready <= !hold_active && ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    // long receiver hold-off so the pipeline fills and backs up the ticks
    always begin
        @(hold_go);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_active <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin : stimulus
        t_drive_cmd no_cmd;
        no_cmd = '{default: '0};
        i_rst_n                   = 1'b0;
        psel                      = 1'b0;
        penable                   = 1'b0;
        pwrite                    = 1'b0;
        paddr                     = '0;
        pwdata                    = '0;
        tick_ch.valid             = 1'b0;
        tick_ch.measured_position = '0;
        tick_ch.measured_velocity = '0;

        shadow_cfg.target_angle = '0;
        shadow_cfg.loop_enable  = 1'b1;
        shadow_cfg.gain_p       = RST_GAIN_P;
        shadow_cfg.gain_i       = RST_GAIN_I;
        shadow_cfg.gain_d       = RST_GAIN_D;
        shadow_cfg.pos_tol      = RST_POS_TOL;
        shadow_cfg.vel_tol      = RST_VEL_TOL;
        integ_acc      = 0;
        last_err       = 0;
        last_pos       = 0;
        first_tick_due = 1'b1;
        build_directed_table();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idle(IDLE_NONE);
        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_CFG)
                write_reg(directed_rows[r].reg_idx, directed_rows[r].wdata);
            else
                send_tick(directed_rows[r].position, directed_rows[r].velocity,
                          directed_rows[r].known, directed_rows[r].cmd);
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            set_idle(t_idle_mode'(ph % 4));
            randomize_config();
            if (ph == 4) -> hold_go;
            repeat (TICKS_PER_PHASE)
                send_tick(random_position(), random_velocity(), 1'b0, no_cmd);
            if (ph == 5) begin
                write_reg(REG_LOOP_ENABLE, 0);
                repeat (12) send_tick(random_position(), random_velocity(), 1'b0, no_cmd);
                write_reg(REG_LOOP_ENABLE, 1);
            end
        end

        // push the integral far positive, then far negative
        set_idle(IDLE_NONE);
        write_reg(REG_GAIN_P, 0);
        write_reg(REG_GAIN_D, 0);
        write_reg(REG_GAIN_I, 1);
        write_reg(REG_TARGET_ANGLE, 180);
        repeat (20)
            send_tick(-1048576 + int'($urandom_range(575, 0)), random_velocity(), 1'b0, no_cmd);
        write_reg(REG_TARGET_ANGLE, -180);
        repeat (40)
            send_tick(1048575 - int'($urandom_range(575, 0)), random_velocity(), 1'b0, no_cmd);
        set_idle(IDLE_BOTH);
        repeat (30) send_tick(random_position(), random_velocity(), 1'b0, no_cmd);

        drain_results();
        if (mismatch_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
